>>> sv/hpq_pkg.sv
package hpq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [DATA_W-1:0] value;
  } hpq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } hpq_out_t;

endpackage

>>> sv/hpq_mem.sv
module hpq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> sv/hpq_ctrl.sv
module hpq_ctrl #(
  parameter int CAPACITY = 64,
  localparam int ADDR_W = $clog2(CAPACITY),
  localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hpq_pkg::hpq_in_t    cmd,
  output logic                busy,
  output logic                done,
  output hpq_pkg::hpq_out_t   result,
  output logic                mem_we,
  output logic [ADDR_W-1:0]   mem_waddr,
  output logic [31:0]         mem_wdata,
  output logic [ADDR_W-1:0]   mem_raddr_a,
  output logic [ADDR_W-1:0]   mem_raddr_b,
  input  logic [31:0]         mem_rdata_a,
  input  logic [31:0]         mem_rdata_b
);
  import hpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_FIN,
    S_DN_FETCH,
    S_DN_CMP
  } state_t;

  state_t                   state, state_next;
  logic [CNT_W-1:0]         cnt, cnt_next;
  logic [CNT_W-1:0]         n, n_next;
  logic [ADDR_W-1:0]        pos, pos_next;
  logic signed [DATA_W-1:0] val, val_next;
  logic signed [DATA_W-1:0] pop_val, pop_val_next;
  logic                     done_next;
  hpq_out_t                 result_next;

  logic                     fin;
  status_t                  fin_status;
  logic signed [DATA_W-1:0] rd_a, rd_b;
  logic [ADDR_W-1:0]        pos_m1, par, par_m1;
  logic [ADDR_W+1:0]        lch, rch, n_ext, best;
  logic signed [DATA_W-1:0] best_v;
  logic [ADDR_W-1:0]        best_a;

  assign rd_a   = mem_rdata_a;
  assign rd_b   = mem_rdata_b;
  assign pos_m1 = pos - ADDR_W'(1);
  assign par    = pos_m1 >> 1;
  assign par_m1 = par - ADDR_W'(1);
  assign lch    = {1'b0, pos, 1'b1};
  assign rch    = lch + (ADDR_W+2)'(1);
  assign n_ext  = (ADDR_W+2)'(n);
  assign best   = (rch < n_ext && rd_b > rd_a) ? rch : lch;
  assign best_v = (rch < n_ext && rd_b > rd_a) ? rd_b : rd_a;
  assign best_a = ADDR_W'(best);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    n_next       = n;
    pos_next     = pos;
    val_next     = val;
    pop_val_next = pop_val;
    fin          = 1'b0;
    fin_status   = ST_OK;
    mem_we       = 1'b0;
    mem_waddr    = pos;
    mem_wdata    = val;
    mem_raddr_a  = '0;
    mem_raddr_b  = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          pop_val_next = '0;
          if (cmd.mode == MODE_PUSH) begin
            if (cnt == CNT_W'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              cnt_next = cnt + CNT_W'(1);
              val_next = cmd.value;
              pos_next = ADDR_W'(cnt);
              if (cnt == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = cmd.value;
                fin       = 1'b1;
              end else begin
                mem_raddr_a = ADDR_W'((cnt - CNT_W'(1)) >> 1);
                state_next  = S_UP_CMP;
              end
            end
          end else begin
            if (cnt == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              cnt_next    = cnt - CNT_W'(1);
              n_next      = cnt - CNT_W'(1);
              mem_raddr_a = '0;
              mem_raddr_b = ADDR_W'(cnt - CNT_W'(1));
              state_next  = S_DN_FETCH;
            end
          end
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (val > rd_a) begin
          mem_wdata = rd_a;
          pos_next  = par;
          if (par == '0) begin
            state_next = S_FIN;
          end else begin
            mem_raddr_a = par_m1 >> 1;
          end
        end else begin
          fin = 1'b1;
        end
      end
      S_FIN: begin
        mem_we = 1'b1;
        fin    = 1'b1;
      end
      S_DN_FETCH: begin
        pop_val_next = rd_a;
        val_next     = rd_b;
        pos_next     = '0;
        mem_raddr_a  = ADDR_W'(1);
        mem_raddr_b  = ADDR_W'(2);
        state_next   = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (lch >= n_ext || !(best_v > val)) begin
          fin = 1'b1;
        end else begin
          mem_wdata   = best_v;
          pos_next    = best_a;
          mem_raddr_a = ADDR_W'({1'b0, best_a, 1'b1});
          mem_raddr_b = ADDR_W'({1'b0, best_a, 1'b1} + (ADDR_W+2)'(1));
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
    done_next                = fin;
    result_next.popped_value = pop_val_next;
    result_next.status       = fin_status;
    result_next.occupancy    = OCC_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      busy  <= (state_next != S_IDLE);
      done  <= done_next;
    end
    n       <= n_next;
    pos     <= pos_next;
    val     <= val_next;
    pop_val <= pop_val_next;
    if (done_next) begin
      result <= result_next;
    end
  end

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word made no progress");

  a_busy_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result word");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> cnt == CNT_W'(CAPACITY))
    else $error("full status while not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> cnt == '0)
    else $error("empty status while not empty");

endmodule

>>> sv/binary_max_heap_priority_queue.sv
// Push: sifts up level by level; into an empty queue, done comes in the next cycle.
// Pop: fetch, then sift down; full/empty refusals answer in the next cycle.
// One word at a time: one heap level per cycle through the 1W/2R store port pair.
// done is a one-cycle strobe; the receiver cannot stall, so busy depends only on the sift.
// Synchronous active-high rst empties the queue at once; store contents are not cleared.
module binary_max_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hpq_pkg::hpq_in_t  cmd,
  output logic              busy,
  output logic              done,
  output hpq_pkg::hpq_out_t result
);
  import hpq_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr_a;
  logic [ADDR_W-1:0] mem_raddr_b;
  logic [31:0]       mem_rdata_a;
  logic [31:0]       mem_rdata_b;

  hpq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  hpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

endmodule
